// File: hdl/npw_pkg.sv
`default_nettype none

package npw_pkg;

    localparam int PAL_SIZE = 16;
    localparam int IDX_W    = 4;
    localparam int DIST_W   = 20;
    localparam int ADDR_W   = 18;
    localparam int POS_W    = 12;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Console palette as {red, green, blue}, in index order.
    localparam logic [23:0] PALETTE [PAL_SIZE] = '{
        24'h000000, 24'h000080, 24'h008000, 24'h008080,
        24'h800000, 24'h800080, 24'h808000, 24'hC0C0C0,
        24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
        24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
    };

    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]         color_t;
    typedef logic [ADDR_W-1:0]        addr_t;

    typedef struct packed {
        logic  draw;
        addr_t cell_address;
    } place_t;

endpackage

`default_nettype wire

// File: hdl/npw_pixel_if.sv
`default_nettype none

interface npw_pixel_if;
    logic              valid;
    logic              ready;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;

    modport source (output valid, red, green, blue, alpha, x_pos, y_pos, input ready);
    modport sink   (input valid, red, green, blue, alpha, x_pos, y_pos, output ready);
endinterface

`default_nettype wire

// File: hdl/npw_result_if.sv
`default_nettype none

interface npw_result_if;
    logic        valid;
    logic        ready;
    logic        draw;
    logic [17:0] cell_address;
    logic [3:0]  color_index;

    modport source (output valid, draw, cell_address, color_index, input ready);
    modport sink   (input valid, draw, cell_address, color_index, output ready);
endinterface

`default_nettype wire

// File: hdl/npw_dist.sv
`default_nettype none

// Relative distance to every palette entry plus the draw decision and cell address.
// The common c*c term is dropped: p*p - 2*p*c orders entries exactly like (c - p)^2.
module npw_dist #(
    parameter int SCREEN_COLS = 300,
    parameter int SCREEN_ROWS = 220
) (
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic [7:0]         alpha,
    input  wire logic signed [11:0] x_pos,
    input  wire logic signed [11:0] y_pos,
    output npw_pkg::dist_t          pal_dist [npw_pkg::PAL_SIZE],
    output npw_pkg::place_t         place
);

    localparam npw_pkg::addr_t ROW_PITCH = npw_pkg::ADDR_W'(2 * SCREEN_COLS);

    function automatic npw_pkg::dist_t chan_term(input logic [7:0] c, input logic [7:0] p);
        logic [15:0] pp;
        logic [16:0] twopc;
        pp    = 16'(p) * 16'(p);
        twopc = {16'(p) * 16'(c), 1'b0};
        return $signed({4'b0, pp}) - $signed({3'b0, twopc});
    endfunction

    logic x_ok;
    logic y_ok;
    npw_pkg::addr_t addr;

    always_comb
    begin
        for (int i = 0; i < npw_pkg::PAL_SIZE; i++)
        begin
            pal_dist[i] = chan_term(red,   npw_pkg::PALETTE[i][23:16])
                        + chan_term(green, npw_pkg::PALETTE[i][15:8])
                        + chan_term(blue,  npw_pkg::PALETTE[i][7:0]);
        end
    end

    assign x_ok = !x_pos[11] && (32'(x_pos[10:0]) < SCREEN_COLS);
    assign y_ok = !y_pos[11] && (32'(y_pos[10:0]) < SCREEN_ROWS);
    assign addr = npw_pkg::ADDR_W'({7'b0, y_pos[10:0]} * ROW_PITCH)
                + npw_pkg::ADDR_W'({x_pos[10:0], 1'b0});

    assign place.draw         = (alpha == npw_pkg::ALPHA_OPAQUE) && x_ok && y_ok;
    assign place.cell_address = place.draw ? addr : '0;

endmodule

`default_nettype wire

// File: hdl/npw_argmin.sv
`default_nettype none

// Four-level compare tree; on equal distance the lower index is kept.
module npw_argmin (
    input  wire npw_pkg::dist_t pal_dist [npw_pkg::PAL_SIZE],
    output npw_pkg::color_t     best
);

    localparam int LEVELS = npw_pkg::IDX_W;

    npw_pkg::dist_t  lvl_d [LEVELS+1][npw_pkg::PAL_SIZE];
    npw_pkg::color_t lvl_i [LEVELS+1][npw_pkg::PAL_SIZE];

    always_comb
    begin
        for (int l = 0; l <= LEVELS; l++)
        begin
            for (int i = 0; i < npw_pkg::PAL_SIZE; i++)
            begin
                lvl_d[l][i] = '0;
                lvl_i[l][i] = '0;
            end
        end
        for (int i = 0; i < npw_pkg::PAL_SIZE; i++)
        begin
            lvl_d[0][i] = pal_dist[i];
            lvl_i[0][i] = npw_pkg::IDX_W'(i);
        end
        for (int l = 1; l <= LEVELS; l++)
        begin
            for (int i = 0; i < (npw_pkg::PAL_SIZE >> l); i++)
            begin
                if (lvl_d[l-1][2*i+1] < lvl_d[l-1][2*i])
                begin
                    lvl_d[l][i] = lvl_d[l-1][2*i+1];
                    lvl_i[l][i] = lvl_i[l-1][2*i+1];
                end
                else
                begin
                    lvl_d[l][i] = lvl_d[l-1][2*i];
                    lvl_i[l][i] = lvl_i[l-1][2*i];
                end
            end
        end
    end

    assign best = lvl_i[LEVELS][0];

endmodule

`default_nettype wire

// File: hdl/nearest_palette_pixel_writer_core.sv
`default_nettype none

// A pixel word passes through the input, middle and output registers in that order.
// Throughput: one pixel word per clock unless the result channel stalls; each of the
// three registers advances whenever the stage after it is empty or being drained.
// Reset (rst_n low, asynchronous) clears the three stage valid flags only; the payload
// registers are not reset and are never shown without a valid flag.
module nearest_palette_pixel_writer_core #(
    parameter int SCREEN_COLS = 300,
    parameter int SCREEN_ROWS = 220
) (
    input wire logic     clk,
    input wire logic     rst_n,
    npw_pixel_if.sink    pix,
    npw_result_if.source res
);

    // Stage enables. A stage loads when it is empty or its word moves on this cycle.
    logic in_en;
    logic mid_en;
    logic out_en;

    // Input register: the raw pixel word.
    logic               in_valid_reg;
    logic [7:0]         in_red_reg;
    logic [7:0]         in_green_reg;
    logic [7:0]         in_blue_reg;
    logic [7:0]         in_alpha_reg;
    logic signed [11:0] in_x_reg;
    logic signed [11:0] in_y_reg;

    // Middle register: sixteen relative distances plus the draw decision and address.
    logic             mid_valid_reg;
    npw_pkg::dist_t   mid_dist_reg [npw_pkg::PAL_SIZE];
    npw_pkg::place_t  mid_place_reg;

    // Output register: the finished result word.
    logic             out_valid_reg;
    npw_pkg::place_t  out_place_reg;
    npw_pkg::color_t  out_color_reg;

    npw_pkg::dist_t   pal_dist [npw_pkg::PAL_SIZE];
    npw_pkg::place_t  place;
    npw_pkg::color_t  best;

    assign out_en    = !out_valid_reg || res.ready;
    assign mid_en    = !mid_valid_reg || out_en;
    assign in_en     = !in_valid_reg  || mid_en;
    assign pix.ready = in_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                in_valid_reg <= pix.valid;
            end
            if (mid_en)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && pix.valid)
        begin
            in_red_reg   <= pix.red;
            in_green_reg <= pix.green;
            in_blue_reg  <= pix.blue;
            in_alpha_reg <= pix.alpha;
            in_x_reg     <= pix.x_pos;
            in_y_reg     <= pix.y_pos;
        end
        if (mid_en && in_valid_reg)
        begin
            mid_dist_reg  <= pal_dist;
            mid_place_reg <= place;
        end
        if (out_en && mid_valid_reg)
        begin
            out_place_reg <= mid_place_reg;
            // A skipped pixel reports palette index zero.
            out_color_reg <= mid_place_reg.draw ? best : '0;
        end
    end

    npw_dist #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dist (
        .red      (in_red_reg),
        .green    (in_green_reg),
        .blue     (in_blue_reg),
        .alpha    (in_alpha_reg),
        .x_pos    (in_x_reg),
        .y_pos    (in_y_reg),
        .pal_dist (pal_dist),
        .place    (place)
    );

    npw_argmin u_argmin (
        .pal_dist (mid_dist_reg),
        .best     (best)
    );

    assign res.valid        = out_valid_reg;
    assign res.draw         = out_place_reg.draw;
    assign res.cell_address = out_place_reg.cell_address;
    assign res.color_index  = out_color_reg;

    // A skipped pixel carries all-zero address and color fields.
    a_skip_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.draw) |-> (res.cell_address == '0 && res.color_index == '0))
        else $error("skipped pixel carries nonzero fields");

    // Every drawn pixel starts on an even cell, since each pixel spans two cells.
    a_even_cell : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.draw) |-> !res.cell_address[0])
        else $error("drawn pixel starts on an odd cell");

    // With every stage full and the output stalled, no new word may be taken.
    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready && mid_valid_reg && in_valid_reg) |-> !pix.ready)
        else $error("input accepted while pipeline is full and stalled");

    // A stalled middle stage keeps its word until the output register takes it.
    a_mid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && !mid_en) |=> (mid_valid_reg && $stable(mid_place_reg)))
        else $error("middle stage word changed while stalled");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the nearest-palette pixel writer.
module tb_top;

    localparam int SCREEN_COLS = 300;
    localparam int SCREEN_ROWS = 220;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_WORDS_PER_PHASE = 567;

    // The sixteen console colors as {red, green, blue}, in index order. The dark
    // entries use 128, the bright ones 255, and the light gray sits at 192.
    localparam bit [23:0] CONSOLE_COLORS [16] = '{
        24'h000000, 24'h000080, 24'h008000, 24'h008080,
        24'h800000, 24'h800080, 24'h808000, 24'hC0C0C0,
        24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
        24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
    };

    // One expected word on the result channel.
    typedef struct {
        bit        draw;
        bit [17:0] cell_address;
        bit [3:0]  color_index;
    } cell_write_t;

    // The scoreboard turns every accepted pixel into the cell write it must cause
    // and matches the result words against those writes in order.
    class cell_write_scoreboard;
        cell_write_t pending_writes[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Squared RGB distance to every palette entry; a strictly smaller
        // distance is needed to move away from an earlier entry, so ties
        // resolve to the lower index.
        function bit [3:0] nearest_color(bit [7:0] r, bit [7:0] g, bit [7:0] b);
            int best_dist;
            int sq_dist;
            int dr;
            int dg;
            int db;
            bit [3:0] best;
            best_dist = 32'h7FFFFFFF;
            best = '0;
            for (int i = 0; i < 16; i++)
            begin
                dr = int'(r) - int'(CONSOLE_COLORS[i][23:16]);
                dg = int'(g) - int'(CONSOLE_COLORS[i][15:8]);
                db = int'(b) - int'(CONSOLE_COLORS[i][7:0]);
                sq_dist = dr * dr + dg * dg + db * db;
                if (sq_dist < best_dist)
                begin
                    best_dist = sq_dist;
                    best = i[3:0];
                end
            end
            return best;
        endfunction

        function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a,
                                 bit signed [11:0] x, bit signed [11:0] y);
            cell_write_t w;
            int col;
            int row;
            int addr;
            col = int'(x);
            row = int'(y);
            w.draw = 1'b0;
            w.cell_address = '0;
            w.color_index = '0;
            if (a == 8'hFF && col >= 0 && row >= 0 && col < SCREEN_COLS
                && row < SCREEN_ROWS)
            begin
                addr = row * (2 * SCREEN_COLS) + 2 * col;
                w.draw = 1'b1;
                w.cell_address = addr[17:0];
                w.color_index = nearest_color(r, g, b);
            end
            pending_writes.push_back(w);
        endfunction

        function void check_result(bit draw, bit [17:0] cell_address, bit [3:0] color_index);
            cell_write_t w;
            if (pending_writes.size() == 0)
            begin
                $error("result word with no pixel pending: draw %0d cell_address %0d",
                       draw, cell_address);
                errors++;
                return;
            end
            w = pending_writes.pop_front();
            if (draw !== w.draw)
            begin
                $error("draw: expected %0d, actual %0d", w.draw, draw);
                errors++;
            end
            if (cell_address !== w.cell_address)
            begin
                $error("cell_address: expected %0d, actual %0d", w.cell_address, cell_address);
                errors++;
            end
            if (color_index !== w.color_index)
            begin
                $error("color_index: expected %0d, actual %0d", w.color_index, color_index);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    npw_pixel_if  pix_if();
    npw_result_if res_if();

    nearest_palette_pixel_writer_core #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pix  (pix_if),
        .res  (res_if)
    );

    cell_write_scoreboard sb;

    // Percent chance, per cycle, that the sender holds back a word or that the
    // receiver refuses one. The stimulus process changes them between phases.
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.red = '0;
        pix_if.green = '0;
        pix_if.blue = '0;
        pix_if.alpha = '0;
        pix_if.x_pos = '0;
        pix_if.y_pos = '0;
        res_if.ready = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 56;
        cycle_count = 0;
        sb = new();
    end

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL nearest_palette_pixel_writer_core");
            $finish;
        end
    end

    // The receiver decides afresh on every edge whether it takes a word.
    always @(posedge clk)
    begin
        if (rst_n)
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        else
            res_if.ready <= 1'b0;
    end

    // Both monitors sample at the edge itself, so they see the values that the
    // block saw; anything driven at this edge lands only after they have run.
    always @(posedge clk)
    begin
        if (rst_n && pix_if.valid && pix_if.ready)
            sb.note_pixel(pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha,
                          pix_if.x_pos, pix_if.y_pos);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.draw, res_if.cell_address, res_if.color_index);
    end

    // Offers one pixel word, after a random number of idle cycles, and returns
    // at the edge where the block accepts it. The next call may then raise the
    // same valid again without a gap, which keeps back-to-back words possible.
    task automatic send_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                              input bit [7:0] a, input bit [11:0] x, input bit [11:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red <= r;
        pix_if.green <= g;
        pix_if.blue <= b;
        pix_if.alpha <= a;
        pix_if.x_pos <= x;
        pix_if.y_pos <= y;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    // Drops valid and holds off until every pixel sent so far has produced its
    // result word.
    task automatic wait_for_drain();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // A channel value near a palette level, clipped to the 8-bit range, so that
    // many pixels fall close to the decision boundaries between entries.
    function automatic bit [7:0] jitter_channel(bit [7:0] level);
        int v;
        v = int'(level) + int'($urandom_range(48)) - 24;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic send_random_pixel();
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        bit [7:0] a;
        bit [11:0] x;
        bit [11:0] y;
        int kind;
        int entry;
        kind = $urandom_range(99);
        entry = $urandom_range(15);
        // Color: half fully random, half scattered around one palette entry.
        if ($urandom_range(1) == 0)
        begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
        end
        else
        begin
            r = jitter_channel(CONSOLE_COLORS[entry][23:16]);
            g = jitter_channel(CONSOLE_COLORS[entry][15:8]);
            b = jitter_channel(CONSOLE_COLORS[entry][7:0]);
        end
        // Placement: mostly an opaque pixel on screen, which is the only case
        // that exercises the address and palette paths.
        a = 8'hFF;
        x = 12'($urandom_range(SCREEN_COLS - 1));
        y = 12'($urandom_range(SCREEN_ROWS - 1));
        if (kind < 10)
            a = 8'($urandom_range(254));
        else if (kind < 20)
        begin
            x = 12'($urandom_range(4095));
            y = 12'($urandom_range(4095));
        end
        else if (kind < 26)
        begin
            a = 8'($urandom_range(255));
            x = 12'($urandom_range(4095));
            y = 12'($urandom_range(4095));
        end
        else if (kind < 32)
        begin
            // Just inside or just outside one of the four screen borders.
            case ($urandom_range(3))
                0: x = 12'hFFF;
                1: x = 12'(SCREEN_COLS - $urandom_range(1));
                2: y = 12'hFFF;
                default: y = 12'(SCREEN_ROWS - $urandom_range(1));
            endcase
        end
        send_pixel(r, g, b, a, x, y);
    endtask

    initial
    begin
        int col;
        int row;
        int x_int;
        int y_int;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every palette color exactly, opaque and on screen; the first lands on
        // the top left cell and the last on the bottom right one.
        for (int i = 0; i < 16; i++)
        begin
            col = $urandom_range(SCREEN_COLS - 1);
            row = $urandom_range(SCREEN_ROWS - 1);
            if (i == 0)
            begin
                col = 0;
                row = 0;
            end
            if (i == 15)
            begin
                col = SCREEN_COLS - 1;
                row = SCREEN_ROWS - 1;
            end
            send_pixel(CONSOLE_COLORS[i][23:16], CONSOLE_COLORS[i][15:8],
                       CONSOLE_COLORS[i][7:0], 8'hFF, col[11:0], row[11:0]);
        end

        // Equal distance to two entries: the lower index has to win.
        send_pixel(8'd64, 8'd0, 8'd0, 8'hFF, 12'd5, 12'd7);
        send_pixel(8'd160, 8'd160, 8'd160, 8'hFF, 12'd17, 12'd3);

        // Translucent pixels are never drawn, however close to opaque.
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE, 12'd10, 12'd10);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0);

        // Positions one step off each border and at the far ends of the range.
        x_int = SCREEN_COLS;
        y_int = SCREEN_ROWS;
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 12'hFFF, 12'd0);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, x_int[11:0], 12'd0);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 12'd0, 12'hFFF);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 12'd0, y_int[11:0]);
        send_pixel(8'hFF, 8'hFF, 8'h00, 8'hFF, 12'h800, 12'h7FF);
        send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 12'h7FF, 12'h800);

        // Random traffic in three phases: a slow receiver, then a slow sender,
        // then both sides at full rate. Between phases the sender waits until the
        // pipeline has emptied completely.
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_for_drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS_PER_PHASE; n++)
                send_random_pixel();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("PASS nearest_palette_pixel_writer_core");
        else
            $display("FAIL nearest_palette_pixel_writer_core");
        $finish;
    end

endmodule

// File: sim.f
hdl/npw_pkg.sv
hdl/npw_pixel_if.sv
hdl/npw_result_if.sv
hdl/npw_dist.sv
hdl/npw_argmin.sv
hdl/nearest_palette_pixel_writer_core.sv
test/tb_top.sv
